// ===== hw/rtl/itdt_pkg.sv =====
`default_nettype none

package itdt_pkg;

	// width of the value field on the input stream
	localparam int IN_W = 32;

	localparam int VALUE_BITS_DEF = 32;
	localparam int MAX_DIGITS_DEF = 10;

	localparam int CHAR_W = 6;

	typedef logic [3:0] digit_t;
	typedef logic [CHAR_W-1:0] char_t;

	localparam char_t CHAR_ZERO  = 6'd48;
	localparam char_t CHAR_MINUS = 6'd45;

	// a bcd digit at or above this value overflows when doubled
	localparam digit_t DIGIT_ADJ_MIN = 4'd5;
	localparam digit_t DIGIT_ADJ     = 4'd3;

endpackage

`default_nettype wire

// ===== hw/rtl/itdt_dabble_step.sv =====
`default_nettype none

module itdt_dabble_step
	import itdt_pkg::*;
#(
	parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
	input  wire digit_t [MAX_DIGITS-1:0] bcd,
	input  wire                          bit_in,
	output digit_t      [MAX_DIGITS-1:0] bcd_next,
	output logic                         carry
);

	digit_t [MAX_DIGITS-1:0] adj;

	// add three to every digit of five or more, then shift the whole register left
	always_comb begin
		for (int i = 0; i < MAX_DIGITS; i++) begin
			adj[i] = (bcd[i] >= DIGIT_ADJ_MIN) ? digit_t'(bcd[i] + DIGIT_ADJ) : bcd[i];
		end
	end

	assign {carry, bcd_next} = {adj, bit_in};

endmodule

`default_nettype wire

// ===== hw/rtl/integer_to_decimal_text.sv =====
// decimal text of a signed integer, one character per output transfer, msd first
// after accept, the magnitude is shifted into the bcd digits one bit per cycle through the
// single bcd unit, leading zeros are scanned off, then the minus sign for a negative value
// and the digits are emitted whenever the output register is free; a new value is accepted
// only once the last character of the previous one has been loaded into the output register
// reset: arst_n clears the sequencer and the output valid asynchronously
`default_nettype none

module integer_to_decimal_text
	import itdt_pkg::*;
#(
	parameter int VALUE_BITS = VALUE_BITS_DEF,
	parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
	input  wire         clk,
	input  wire         arst_n,

	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	input  wire  [31:0] s_axis_tdata,   // value[31:0]

	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	output logic [7:0]  m_axis_tdata,   // text_char[5:0], zero[7:6]
	output logic        m_axis_tlast
);

	localparam int CNT_W = $clog2(VALUE_BITS);
	localparam int IDX_W = $clog2(MAX_DIGITS);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SHIFT,
		ST_SCAN,
		ST_SIGN,
		ST_EMIT
	} state_t;

	state_t                  state_q;
	logic [VALUE_BITS-1:0]   mag_q;
	digit_t [MAX_DIGITS-1:0] bcd_q;
	logic                    ovf_q;
	logic                    neg_q;
	logic [CNT_W-1:0]        bitcnt_q;
	logic [IDX_W-1:0]        digidx_q;
	char_t                   char_q;
	logic                    last_q;
	logic                    valid_q;

	logic [VALUE_BITS-1:0]   val_ext;
	logic                    val_neg;
	logic [VALUE_BITS-1:0]   val_mag;
	digit_t [MAX_DIGITS-1:0] bcd_next;
	logic                    carry;
	digit_t                  cur_digit;
	logic                    in_xfer;
	logic                    out_free;
	logic                    char_load;

	generate
		if (VALUE_BITS > IN_W) begin : g_zext
			assign val_ext = {{(VALUE_BITS - IN_W){1'b0}}, s_axis_tdata};
		end else if (VALUE_BITS == IN_W) begin : g_same
			assign val_ext = s_axis_tdata;
		end else begin : g_trunc
			assign val_ext = s_axis_tdata[VALUE_BITS-1:0];
		end
	endgenerate

	// two's complement magnitude stays correct for the most negative value
	assign val_neg = val_ext[VALUE_BITS-1];
	assign val_mag = val_neg ? (~val_ext + VALUE_BITS'(1)) : val_ext;

	itdt_dabble_step #(
		.MAX_DIGITS(MAX_DIGITS)
	) u_step (
		.bcd      (bcd_q),
		.bit_in   (mag_q[VALUE_BITS-1]),
		.bcd_next (bcd_next),
		.carry    (carry)
	);

	assign cur_digit     = bcd_q[digidx_q];
	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_xfer       = s_axis_tvalid && s_axis_tready;
	assign out_free      = !valid_q || m_axis_tready;
	assign char_load     = out_free && (state_q == ST_SIGN || state_q == ST_EMIT);

	assign m_axis_tvalid = valid_q;
	assign m_axis_tdata  = {2'b00, char_q};
	assign m_axis_tlast  = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			mag_q    <= '0;
			bcd_q    <= '0;
			ovf_q    <= 1'b0;
			neg_q    <= 1'b0;
			bitcnt_q <= '0;
			digidx_q <= '0;
			char_q   <= '0;
			last_q   <= 1'b0;
			valid_q  <= 1'b0;
		end else begin
			if (char_load) begin
				valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						mag_q    <= val_mag;
						neg_q    <= val_neg;
						bcd_q    <= '0;
						ovf_q    <= 1'b0;
						bitcnt_q <= '0;
						state_q  <= ST_SHIFT;
					end
				end
				ST_SHIFT: begin
					bcd_q    <= bcd_next;
					ovf_q    <= ovf_q | carry;
					mag_q    <= {mag_q[VALUE_BITS-2:0], 1'b0};
					bitcnt_q <= bitcnt_q + CNT_W'(1);
					if (bitcnt_q == CNT_W'(VALUE_BITS - 1)) begin
						digidx_q <= IDX_W'(MAX_DIGITS - 1);
						state_q  <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					// skip leading zeros, keep all digits when high digits were dropped
					if (!ovf_q && digidx_q != '0 && cur_digit == '0) begin
						digidx_q <= digidx_q - IDX_W'(1);
					end else begin
						state_q <= neg_q ? ST_SIGN : ST_EMIT;
					end
				end
				ST_SIGN: begin
					if (out_free) begin
						char_q  <= CHAR_MINUS;
						last_q  <= 1'b0;
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						char_q  <= char_t'(CHAR_ZERO + char_t'(cur_digit));
						last_q  <= (digidx_q == '0);
						if (digidx_q == '0) begin
							state_q <= ST_IDLE;
						end else begin
							digidx_q <= digidx_q - IDX_W'(1);
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/itdt_checker.sv =====
`default_nettype none

module itdt_checker
	import itdt_pkg::*;
(
	input wire       clk,
	input wire       arst_n,
	input wire       s_axis_tvalid,
	input wire       s_axis_tready,
	input wire       m_axis_tvalid,
	input wire       m_axis_tready,
	input wire [7:0] m_axis_tdata,
	input wire       m_axis_tlast
);

	// the block is busy right after taking an item
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input ready right after an accepted transfer");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
			&& $stable(m_axis_tlast))
		else $error("stalled output transfer changed");

	a_char_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[7:6] == 2'b00 && (m_axis_tdata[5:0] == CHAR_MINUS
			|| (m_axis_tdata[5:0] >= CHAR_ZERO && m_axis_tdata[5:0] <= 6'd57)))
		else $error("output character out of range");

	a_minus_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[5:0] == CHAR_MINUS |-> !m_axis_tlast)
		else $error("minus sign flagged as last character");

endmodule

bind integer_to_decimal_text itdt_checker u_itdt_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
